// ----- hw/rtl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern search unit.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Window depth and the longest pattern that can take part in a match
    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Pattern bytes held in the two pattern registers
    localparam int PAT_BYTES   = 16;

    localparam int ADDR_W      = 64;
    localparam int POS_W       = 32;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_CARE_MASK      = 3'd2,
        CFG_PATTERN_LENGTH = 3'd3,
        CFG_BASE_ADDRESS   = 3'd4
    } cfg_index_t;

    typedef logic [MAX_PATTERN-1:0][7:0] window_t;
    typedef logic [PAT_BYTES-1:0][7:0]   pattern_t;

    // Input item: one byte of the region
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // Result item
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } result_item_t;

endpackage

// ----- hw/rtl/mbps_match.sv -----
// ----------------------------------------------------------------------------
// mbps_match
// Masked compare of the newest window bytes against the configured pattern.
// ----------------------------------------------------------------------------
module mbps_match
    import mbps_pkg::*;
(
    input  window_t          window,
    input  pattern_t         pattern,
    input  logic [15:0]      care_mask,
    input  logic [LEN_W-1:0] match_length,
    output logic             hit
);

    // Pattern byte k lines up with the byte received match_length-1-k items ago
    always_comb
    begin
        logic             mismatch;
        logic [LEN_W-1:0] tap;
        mismatch = 1'b0;
        tap      = '0;
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            if (k < int'(match_length))
            begin
                tap = match_length - LEN_W'(k) - LEN_W'(1);
                if (care_mask[k] && (window[tap[IDX_W-1:0]] != pattern[k]))
                begin
                    mismatch = 1'b1;
                end
            end
        end
        hit = !mismatch;
    end

endmodule

// ----- hw/rtl/masked_byte_pattern_search_unit.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_unit
// Scans a byte stream for a masked pattern and reports the first match.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a region enter on the byte channel (byte_valid / byte_stall),
//   one per item, with last_byte set on the final byte. For each region one
//   result leaves on the result channel (result_valid / result_stall):
//   found=1 with the start address of the first match, or found=0 and
//   address zero when the region ends without a match.
//   Configuration registers are to be written on the cfg channel only while
//   the unit is idle; the unit does not enforce this. cfg_ready is always high.
// Timing:
//   A byte is captured in an input register, compared against the window
//   in one pass of logic, and a result, when one is due, lands in the result
//   register: the input register and then the result register lie between
//   byte and result. One byte is accepted every cycle while result_stall is low.
// Reset and stall:
//   Reset clears the window, byte count and match flag and loads the
//   register defaults (pattern length 1). While result_stall holds a pending
//   result, the input register fills and then byte_stall rises.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_unit
    import mbps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  byte_item_t           byte_item,

    output logic                 result_valid,
    input  logic                 result_stall,
    output result_item_t         result_item,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    // Configuration registers
    logic [63:0]       pattern_low_reg;
    logic [63:0]       pattern_high_reg;
    logic [15:0]       care_mask_reg;
    logic [4:0]        pattern_length_reg;
    logic [ADDR_W-1:0] base_address_reg;

    // Input register
    logic              in_valid_reg;
    byte_item_t        in_item_reg;

    // Region state
    window_t           window_reg;
    window_t           window_next;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  position_next;
    logic              reported_reg;

    // Result register
    logic              out_valid_reg;
    result_item_t      out_item_reg;

    logic              fire;
    logic [LEN_W-1:0]  match_length;
    logic              window_hit;
    logic              hit;
    logic              emit;
    logic [POS_W-1:0]  offset;
    result_item_t      result_next;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= 5'd1;
            base_address_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                CFG_CARE_MASK:      care_mask_reg      <= cfg_data[15:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                CFG_BASE_ADDRESS:   base_address_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Advance the compare stage when the result register can take a result
    assign fire       = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !fire;

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_valid && !byte_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_item_reg <= byte_item;
        end
    end

    // Shift the new byte in and count it, saturating
    always_comb
    begin
        window_next   = {window_reg[MAX_PATTERN-2:0], in_item_reg.data_byte};
        position_next = (position_reg == '1) ? position_reg : position_reg + POS_W'(1);
    end

    // Clamp the pattern length to the window depth
    always_comb
    begin
        if (int'(pattern_length_reg) > MAX_PATTERN)
        begin
            match_length = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            match_length = LEN_W'(pattern_length_reg);
        end
    end

    mbps_match u_match (
        .window       (window_next),
        .pattern      ({pattern_high_reg, pattern_low_reg}),
        .care_mask    (care_mask_reg),
        .match_length (match_length),
        .hit          (window_hit)
    );

    // Decide hit, result and address
    always_comb
    begin
        if (match_length == '0)
        begin
            hit    = 1'b1;
            offset = '0;
        end
        else
        begin
            hit    = window_hit && (position_next >= POS_W'(match_length));
            offset = position_next - POS_W'(match_length);
        end
        emit                      = !reported_reg && (hit || in_item_reg.last_byte);
        result_next.found         = hit;
        result_next.match_address = hit ? (base_address_reg + ADDR_W'(offset)) : '0;
    end

    // Update region state; drop it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            position_reg <= '0;
            reported_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (in_item_reg.last_byte)
            begin
                window_reg   <= '0;
                position_reg <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                window_reg   <= window_next;
                position_reg <= position_next;
                reported_reg <= reported_reg || hit;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= emit;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_item_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule
